// File: hdl/tdfg_pkg.sv
package tdfg_pkg;

  // field widths
  localparam int FreqW = 13;
  localparam int UtilW = 10;
  localparam int TempW = 16;

  // wide enough for (recovered - temp) * 4 plus a frequency
  localparam int ChangeW = 21;

  // configuration port
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int IdxW  = 3;

  typedef enum logic [IdxW-1:0] {
    REG_MIN_FREQ       = 3'd0,
    REG_MAX_FREQ       = 3'd1,
    REG_MAX_INCREASE   = 3'd2,
    REG_UP_THRESHOLD   = 3'd3,
    REG_DOWN_THRESHOLD = 3'd4,
    REG_CRITICAL_TEMP  = 3'd5,
    REG_RECOVERED_TEMP = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [FreqW-1:0]        MinFreqRst       = 13'd1000;
  localparam logic [FreqW-1:0]        MaxFreqRst       = 13'd4000;
  localparam logic [FreqW-1:0]        MaxIncreaseRst   = 13'd1000;
  localparam logic [UtilW-1:0]        UpThresholdRst   = 10'd800;
  localparam logic [UtilW-1:0]        DownThresholdRst = 10'd400;
  localparam logic signed [TempW-1:0] CriticalTempRst  = 16'sd8000;
  localparam logic signed [TempW-1:0] RecoveredTempRst = 16'sd7800;

  typedef struct packed {
    logic                    round_start;
    logic signed [TempW-1:0] peak_temperature;
    logic                    core_active;
    logic [UtilW-1:0]        utilization;
    logic signed [TempW-1:0] core_temperature;
    logic [FreqW-1:0]        old_frequency;
  } sample_t;

  typedef struct packed {
    logic [FreqW-1:0] new_frequency;
    logic             throttled;
  } result_t;

  typedef struct packed {
    logic [FreqW-1:0]        min_freq;
    logic [FreqW-1:0]        max_freq;
    logic [FreqW-1:0]        max_increase;
    logic [UtilW-1:0]        up_threshold;
    logic [UtilW-1:0]        down_threshold;
    logic signed [TempW-1:0] critical_temp;
    logic signed [TempW-1:0] recovered_temp;
  } cfg_t;

endpackage

// File: hdl/tdfg_regs.sv
module tdfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdfg_pkg::AddrW-1:0]  paddr,
  input  logic [tdfg_pkg::DataW-1:0]  pwdata,
  output logic [tdfg_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output tdfg_pkg::cfg_t              cfg
);

  tdfg_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = tdfg_pkg::reg_idx_t'(paddr[tdfg_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_freq       <= tdfg_pkg::MinFreqRst;
      cfg.max_freq       <= tdfg_pkg::MaxFreqRst;
      cfg.max_increase   <= tdfg_pkg::MaxIncreaseRst;
      cfg.up_threshold   <= tdfg_pkg::UpThresholdRst;
      cfg.down_threshold <= tdfg_pkg::DownThresholdRst;
      cfg.critical_temp  <= tdfg_pkg::CriticalTempRst;
      cfg.recovered_temp <= tdfg_pkg::RecoveredTempRst;
    end else if (wr_en) begin
      unique case (idx)
        tdfg_pkg::REG_MIN_FREQ:       cfg.min_freq       <= pwdata[tdfg_pkg::FreqW-1:0];
        tdfg_pkg::REG_MAX_FREQ:       cfg.max_freq       <= pwdata[tdfg_pkg::FreqW-1:0];
        tdfg_pkg::REG_MAX_INCREASE:   cfg.max_increase   <= pwdata[tdfg_pkg::FreqW-1:0];
        tdfg_pkg::REG_UP_THRESHOLD:   cfg.up_threshold   <= pwdata[tdfg_pkg::UtilW-1:0];
        tdfg_pkg::REG_DOWN_THRESHOLD: cfg.down_threshold <= pwdata[tdfg_pkg::UtilW-1:0];
        tdfg_pkg::REG_CRITICAL_TEMP:  cfg.critical_temp  <= pwdata[tdfg_pkg::TempW-1:0];
        tdfg_pkg::REG_RECOVERED_TEMP: cfg.recovered_temp <= pwdata[tdfg_pkg::TempW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    prdata = '0;
    unique case (idx)
      tdfg_pkg::REG_MIN_FREQ:       prdata = tdfg_pkg::DataW'(cfg.min_freq);
      tdfg_pkg::REG_MAX_FREQ:       prdata = tdfg_pkg::DataW'(cfg.max_freq);
      tdfg_pkg::REG_MAX_INCREASE:   prdata = tdfg_pkg::DataW'(cfg.max_increase);
      tdfg_pkg::REG_UP_THRESHOLD:   prdata = tdfg_pkg::DataW'(cfg.up_threshold);
      tdfg_pkg::REG_DOWN_THRESHOLD: prdata = tdfg_pkg::DataW'(cfg.down_threshold);
      tdfg_pkg::REG_CRITICAL_TEMP:  prdata = tdfg_pkg::DataW'($unsigned(cfg.critical_temp));
      tdfg_pkg::REG_RECOVERED_TEMP: prdata = tdfg_pkg::DataW'($unsigned(cfg.recovered_temp));
      default:                      prdata = '0;
    endcase
  end

endmodule

// File: hdl/tdfg_calc.sv
module tdfg_calc (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  tdfg_pkg::cfg_t    cfg,
  input  tdfg_pkg::sample_t sample,
  output tdfg_pkg::result_t result
);

  localparam int CW = tdfg_pkg::ChangeW;
  localparam int FW = tdfg_pkg::FreqW;

  logic throttle;
  logic throttle_next;

  logic signed [CW-1:0] diff;
  logic signed [CW-1:0] step;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] old_ext;
  logic signed [CW-1:0] max_inc_ext;
  logic signed [CW-1:0] max_freq_ext;
  logic [FW-1:0]        half;
  logic [FW-1:0]        freq;

  // hysteresis, set test first
  always_comb begin
    throttle_next = throttle;
    if (sample.round_start) begin
      if ($signed(sample.peak_temperature) > $signed(cfg.critical_temp)) begin
        throttle_next = 1'b1;
      end else if ($signed(sample.peak_temperature) < $signed(cfg.recovered_temp)) begin
        throttle_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle <= 1'b0;
    end else if (advance) begin
      throttle <= throttle_next;
    end
  end

  always_comb begin
    old_ext      = $signed({{(CW-FW){1'b0}}, sample.old_frequency});
    max_inc_ext  = $signed({{(CW-FW){1'b0}}, cfg.max_increase});
    max_freq_ext = $signed({{(CW-FW){1'b0}}, cfg.max_freq});
    diff = CW'($signed(cfg.recovered_temp)) - CW'($signed(sample.core_temperature));

    // negative change counts four times, positive is capped
    if (diff < 0) begin
      step = diff <<< 2;
    end else if (diff > max_inc_ext) begin
      step = max_inc_ext;
    end else begin
      step = diff;
    end

    sum = old_ext + step;
    if (sum > max_freq_ext) begin
      sum = max_freq_ext;
    end
    if (sum < 0) begin
      sum = '0;
    end

    half = sample.old_frequency >> 1;

    if (throttle_next || !sample.core_active) begin
      freq = cfg.min_freq;
    end else if (sample.utilization > cfg.up_threshold) begin
      freq = sum[FW-1:0];
    end else if (sample.utilization < cfg.down_threshold) begin
      if (sample.old_frequency == cfg.min_freq) begin
        freq = sample.old_frequency;
      end else if (half < cfg.min_freq) begin
        freq = cfg.min_freq;
      end else begin
        freq = half;
      end
    end else begin
      freq = sample.old_frequency;
    end

    result.new_frequency = freq;
    result.throttled     = throttle_next;
  end

endmodule

// File: hdl/thermal_dvfs_frequency_governor_core.sv
// thermal dvfs frequency governor
//
// sample channel (sample_valid / sample_ready / sample): one core sample per
// transaction; a sample with round_start set re-evaluates the throttle flag
// from peak_temperature before that core's frequency is chosen
// result channel (result_valid / result_ready / result): one transaction per
// sample, in order, carrying new_frequency and the throttle flag
// apb port: seven registers at byte address 4*index, written in the access
// phase, pready always high, reads return the register zero extended
//
// a sample transaction reaches result valid through the input register, then
// the result register; throughput is one sample per cycle while the receiver
// does not stall, set by the single stage of compare/add logic between them
// reset empties both stages, clears the throttle flag and loads the register
// defaults; when the receiver stalls the result register holds and an empty
// input register still takes one more sample before sample_ready drops
module thermal_dvfs_frequency_governor_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  tdfg_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output tdfg_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdfg_pkg::AddrW-1:0]  paddr,
  input  logic [tdfg_pkg::DataW-1:0]  pwdata,
  output logic [tdfg_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  tdfg_pkg::cfg_t    cfg;
  tdfg_pkg::sample_t s1_data;
  tdfg_pkg::result_t calc_result;
  logic              s1_valid;
  logic              out_free;
  logic              advance;

  // configuration registers
  tdfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register can load when empty or being drained
  assign out_free     = !result_valid || result_ready;
  assign advance      = s1_valid && out_free;
  assign sample_ready = !s1_valid || advance;

  // throttle flag moves with the sample that leaves the input register
  tdfg_calc u_calc (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .sample  (s1_data),
    .result  (calc_result)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (sample_ready) begin
        s1_valid <= sample_valid;
      end
      if (out_free) begin
        result_valid <= s1_valid;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_data <= sample;
    end
    if (advance) begin
      result <= calc_result;
    end
  end

endmodule

// File: hdl/tdfg_checker.sv
module tdfg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input tdfg_pkg::result_t           result
);

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // empty pipeline takes a sample after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> sample_ready)
    else $error("sample not ready after reset");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a sample passes the input register into the result register when the output side is free
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) ##1 (!result_valid || result_ready) |=> result_valid)
    else $error("result missing two cycles after sample transaction");

endmodule

bind thermal_dvfs_frequency_governor_core tdfg_checker u_tdfg_checker (.*);
